>>> rtl/core/ps2mc_pkg.sv
// ----------------------------------------------------------------------------
// ps2mc_pkg
// Shared types and constants of the PS/2 mouse packet cursor block.
// ----------------------------------------------------------------------------
`default_nettype none

package ps2mc_pkg;

    // field widths
    localparam int BYTE_W    = 8;
    localparam int CFG_W     = 13;
    localparam int BTN_W     = 3;
    localparam int DX_W      = 9;
    localparam int DY_W      = 10;
    localparam int APB_W     = 32;
    localparam int PADDR_W   = 3;

    // reset values of the screen bound registers
    localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST  = 13'd1024;
    localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd768;

    // register index, taken from paddr bit 2
    localparam logic REG_SCREEN_WIDTH  = 1'b0;
    localparam logic REG_SCREEN_HEIGHT = 1'b1;

    // input operation codes
    localparam logic OP_DATA     = 1'b0;
    localparam logic OP_RECENTER = 1'b1;

    // bit positions in the flags byte
    localparam int FLAG_SYNC_BIT  = 3;
    localparam int FLAG_XSIGN_BIT = 4;
    localparam int FLAG_YSIGN_BIT = 5;
    localparam int FLAG_XOVF_BIT  = 6;
    localparam int FLAG_YOVF_BIT  = 7;

    // decoded action of one byte, framer to cursor
    typedef struct packed {
        logic                   recenter;
        logic                   emit;
        logic [BTN_W-1:0]       buttons;
        logic signed [DX_W-1:0] delta_x;
        logic signed [DY_W-1:0] delta_y;
    } pkt_t;

endpackage

`default_nettype wire

>>> rtl/core/ps2mc_framer.sv
// ----------------------------------------------------------------------------
// ps2mc_framer
// Frames mouse bytes into three-byte packets and decodes the deltas.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mc_framer (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         advance,
    input  wire logic                         op,
    input  wire logic [ps2mc_pkg::BYTE_W-1:0] data_byte,
    output ps2mc_pkg::pkt_t                   pkt
);
    import ps2mc_pkg::*;

    typedef enum logic [1:0] {
        POS_FLAGS = 2'd0,
        POS_XMOVE = 2'd1,
        POS_YMOVE = 2'd2
    } pos_t;

    pos_t              pos_reg, pos_next;
    logic [BYTE_W-1:0] flags_reg, flags_next;
    logic [BYTE_W-1:0] xmove_reg, xmove_next;
    logic              emit;
    logic signed [DY_W-1:0] dy_raw;

    // packet framing
    always_comb begin
        pos_next   = pos_reg;
        flags_next = flags_reg;
        xmove_next = xmove_reg;
        emit       = 1'b0;
        if (op == OP_RECENTER) begin
            pos_next = POS_FLAGS;
        end else begin
            case (pos_reg)
                POS_XMOVE: begin
                    xmove_next = data_byte;
                    pos_next   = POS_YMOVE;
                end
                POS_YMOVE: begin
                    pos_next = POS_FLAGS;
                    emit     = !(flags_reg[FLAG_XOVF_BIT] || flags_reg[FLAG_YOVF_BIT]);
                end
                default: begin
                    // first byte must carry the sync bit, else drop it
                    if (data_byte[FLAG_SYNC_BIT]) begin
                        flags_next = data_byte;
                        pos_next   = POS_XMOVE;
                    end else begin
                        pos_next = POS_FLAGS;
                    end
                end
            endcase
        end
    end

    // sign extension and y negation
    assign dy_raw = $signed({flags_reg[FLAG_YSIGN_BIT], flags_reg[FLAG_YSIGN_BIT], data_byte});

    assign pkt.recenter = (op == OP_RECENTER);
    assign pkt.emit     = emit;
    assign pkt.buttons  = flags_reg[BTN_W-1:0];
    assign pkt.delta_x  = $signed({flags_reg[FLAG_XSIGN_BIT], xmove_reg});
    assign pkt.delta_y  = -dy_raw;

    // framing state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg   <= POS_FLAGS;
            flags_reg <= '0;
            xmove_reg <= '0;
        end else if (advance) begin
            pos_reg   <= pos_next;
            flags_reg <= flags_next;
            xmove_reg <= xmove_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ps2mc_cursor.sv
// ----------------------------------------------------------------------------
// ps2mc_cursor
// Holds the cursor, applies packet deltas and clamps to the screen bounds.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2mc_cursor #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        advance,
    input  wire ps2mc_pkg::pkt_t             pkt,
    input  wire logic [ps2mc_pkg::CFG_W-1:0] screen_width,
    input  wire logic [ps2mc_pkg::CFG_W-1:0] screen_height,
    output logic [COORD_BITS-1:0]            col_next,
    output logic [COORD_BITS-1:0]            row_next
);
    import ps2mc_pkg::*;

    localparam int EW = (CFG_W > COORD_BITS + 1) ? CFG_W : COORD_BITS + 1;
    localparam int BW = COORD_BITS + 1;
    localparam int PW = COORD_BITS + 2;
    localparam logic [EW-1:0] LIMIT = EW'(1) << COORD_BITS;

    localparam int LIMIT_INT = 1 << COORD_BITS;
    localparam int W_RST = (int'(SCREEN_WIDTH_RST) > LIMIT_INT) ? LIMIT_INT
                                                                : int'(SCREEN_WIDTH_RST);
    localparam int H_RST = (int'(SCREEN_HEIGHT_RST) > LIMIT_INT) ? LIMIT_INT
                                                                 : int'(SCREEN_HEIGHT_RST);
    localparam logic [COORD_BITS-1:0] COL_RST = COORD_BITS'(W_RST / 2);
    localparam logic [COORD_BITS-1:0] ROW_RST = COORD_BITS'(H_RST / 2);

    logic [COORD_BITS-1:0] col_reg, row_reg;
    logic [EW-1:0]         w_ext, h_ext;
    logic [BW-1:0]         w_bound, h_bound;
    logic signed [PW-1:0]  col_sum, row_sum;
    logic signed [PW-1:0]  w_bound_s, h_bound_s;
    logic [COORD_BITS-1:0] col_clamp, row_clamp;

    // effective bounds: zero acts as one, saturate at the coordinate range
    always_comb begin
        w_ext = EW'(screen_width);
        h_ext = EW'(screen_height);
        if (w_ext == '0)  w_ext = EW'(1);
        if (w_ext > LIMIT) w_ext = LIMIT;
        if (h_ext == '0)  h_ext = EW'(1);
        if (h_ext > LIMIT) h_ext = LIMIT;
    end

    assign w_bound   = w_ext[BW-1:0];
    assign h_bound   = h_ext[BW-1:0];
    assign w_bound_s = $signed({1'b0, w_bound});
    assign h_bound_s = $signed({1'b0, h_bound});

    // add deltas
    assign col_sum = $signed({2'b00, col_reg}) + PW'($signed(pkt.delta_x));
    assign row_sum = $signed({2'b00, row_reg}) + PW'($signed(pkt.delta_y));

    // clamp to [0, bound-1]
    always_comb begin
        if (col_sum < 0) begin
            col_clamp = '0;
        end else if (col_sum >= w_bound_s) begin
            col_clamp = COORD_BITS'(w_bound - BW'(1));
        end else begin
            col_clamp = col_sum[COORD_BITS-1:0];
        end
        if (row_sum < 0) begin
            row_clamp = '0;
        end else if (row_sum >= h_bound_s) begin
            row_clamp = COORD_BITS'(h_bound - BW'(1));
        end else begin
            row_clamp = row_sum[COORD_BITS-1:0];
        end
    end

    // next cursor: recenter, packet move or hold
    always_comb begin
        if (pkt.recenter) begin
            col_next = w_bound[BW-1:1];
            row_next = h_bound[BW-1:1];
        end else if (pkt.emit) begin
            col_next = col_clamp;
            row_next = row_clamp;
        end else begin
            col_next = col_reg;
            row_next = row_reg;
        end
    end

    // cursor state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= COL_RST;
            row_reg <= ROW_RST;
        end else if (advance) begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/ps2_mouse_packet_cursor.sv
// ----------------------------------------------------------------------------
// ps2_mouse_packet_cursor
// Frames PS/2 mouse bytes into three-byte packets and tracks a clamped cursor.
// ----------------------------------------------------------------------------
//
//  channel   | ports                         | carries
//  ----------+-------------------------------+-------------------------------
//  input     | s_valid s_ready s_op s_data_* | mouse byte or recenter request
//  result    | m_valid m_ready m_cursor_*    | cursor, buttons, deltas
//  config    | psel penable pwrite paddr ... | screen width and height
//
//  One item per cycle while the result side does not stall it: an item waits
//  in the input register, then the framer and the cursor add/clamp update state.
//  An item that completes a packet without overflow waits only for the result
//  register to be free; other items never wait on the result side.
//  Reset is synchronous, active low; the cursor comes up at half the reset
//  screen size, framing at the first byte, bounds at 1024 by 768.
// ----------------------------------------------------------------------------
`default_nettype none

module ps2_mouse_packet_cursor #(
    parameter int COORD_BITS = 12
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    // input channel
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_op,
    input  wire logic [ps2mc_pkg::BYTE_W-1:0]   s_data_byte,
    // result channel
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [COORD_BITS-1:0]               m_cursor_x,
    output logic [COORD_BITS-1:0]               m_cursor_y,
    output logic [ps2mc_pkg::BTN_W-1:0]         m_buttons,
    output logic signed [ps2mc_pkg::DX_W-1:0]   m_delta_x,
    output logic signed [ps2mc_pkg::DY_W-1:0]   m_delta_y,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [ps2mc_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [ps2mc_pkg::APB_W-1:0]    pwdata,
    output logic [ps2mc_pkg::APB_W-1:0]         prdata,
    output logic                                pready
);
    import ps2mc_pkg::*;

    logic              in_vld_reg;
    logic              op_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic              out_free;
    logic              advance;
    pkt_t              pkt;

    logic [CFG_W-1:0]  width_reg, height_reg;
    logic              cfg_write;

    logic [COORD_BITS-1:0]  col_next, row_next;
    logic                   m_vld_reg;
    logic [COORD_BITS-1:0]  cx_reg, cy_reg;
    logic [BTN_W-1:0]       btn_reg;
    logic signed [DX_W-1:0] dx_reg;
    logic signed [DY_W-1:0] dy_reg;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= SCREEN_WIDTH_RST;
            height_reg <= SCREEN_HEIGHT_RST;
        end else if (cfg_write) begin
            if (paddr[2] == REG_SCREEN_WIDTH) begin
                width_reg <= pwdata[CFG_W-1:0];
            end else begin
                height_reg <= pwdata[CFG_W-1:0];
            end
        end
    end

    always_comb begin
        if (paddr[2] == REG_SCREEN_HEIGHT) begin
            prdata = APB_W'(height_reg);
        end else begin
            prdata = APB_W'(width_reg);
        end
    end

    // handshake: an item moves on unless it emits a packet and the
    // result register is still full
    assign out_free = !m_vld_reg || m_ready;
    assign advance  = in_vld_reg && (!pkt.emit || out_free);
    assign s_ready  = !in_vld_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            op_reg   <= s_op;
            byte_reg <= s_data_byte;
        end
    end

    // packet framing
    ps2mc_framer u_framer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .advance   (advance),
        .op        (op_reg),
        .data_byte (byte_reg),
        .pkt       (pkt)
    );

    // cursor update and clamp
    ps2mc_cursor #(
        .COORD_BITS (COORD_BITS)
    ) u_cursor (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .advance       (advance),
        .pkt           (pkt),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .col_next      (col_next),
        .row_next      (row_next)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (advance && pkt.emit) begin
            m_vld_reg <= 1'b1;
        end else if (m_ready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && pkt.emit) begin
            cx_reg  <= col_next;
            cy_reg  <= row_next;
            btn_reg <= pkt.buttons;
            dx_reg  <= pkt.delta_x;
            dy_reg  <= pkt.delta_y;
        end
    end

    assign m_valid    = m_vld_reg;
    assign m_cursor_x = cx_reg;
    assign m_cursor_y = cy_reg;
    assign m_buttons  = btn_reg;
    assign m_delta_x  = dx_reg;
    assign m_delta_y  = dy_reg;

endmodule

`default_nettype wire
